### design/dssm_pkg.sv
// Shared constants, codes and types for the dual stack shared memory block.
`timescale 1ns / 1ps

package dssm_pkg;

  localparam int DEPTH    = 16;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int LEVEL_W  = $clog2(DEPTH + 1);
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_LOW  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PUSH_HIGH = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_LOW   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_HIGH  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_TOP = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic {
    SEQ_IDLE,
    SEQ_POP_WAIT
  } seq_state_t;

endpackage

### design/dssm_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dual_stack_shared_memory.sv
// Top level: two LIFO stacks sharing one RAM, with the command sequencer.
`timescale 1ns / 1ps

// Channel    Handshake            Payload
// ---------  -------------------  -----------------------------------------------
// command    start & !busy        action, push_value
// result     done (one cycle)     status, low_top, high_top, low_count,
//                                 high_count, low_empty, high_empty, full_res
//
// A query, a push or a refused command never sets busy: its result strobes in
// the cycle after acceptance and a new item can be accepted in that same cycle.
// A pop that leaves entries behind passes through SEQ_POP_WAIT, since the new top
// must be read from the registered RAM read port; busy is high in that state.
// Reset empties both stacks; RAM contents are left as they are and are only
// read at entries a push has written. The receiver cannot stall the result.

module dual_stack_shared_memory (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [dssm_pkg::ACTION_W-1:0]         action,
  input  logic signed [dssm_pkg::WORD_W-1:0]    push_value,
  output logic                                  busy,
  output logic                                  done,
  output logic [dssm_pkg::STATUS_W-1:0]         status,
  output logic signed [dssm_pkg::WORD_W-1:0]    low_top,
  output logic signed [dssm_pkg::WORD_W-1:0]    high_top,
  output logic [dssm_pkg::LEVEL_W-1:0]          low_count,
  output logic [dssm_pkg::LEVEL_W-1:0]          high_count,
  output logic                                  low_empty,
  output logic                                  high_empty,
  output logic                                  full_res
);

  import dssm_pkg::*;

  seq_state_t state, state_next;

  // Stack levels and cached top words; the cache spares a RAM read on
  // every command except a pop that uncovers an older entry.
  logic [LEVEL_W-1:0]        low_level, low_level_next;
  logic [LEVEL_W-1:0]        high_level, high_level_next;
  logic signed [WORD_W-1:0]  low_word, low_word_next;
  logic signed [WORD_W-1:0]  high_word, high_word_next;
  logic [STATUS_W-1:0]       stat, stat_next;
  logic                      done_next;
  logic                      wait_low, wait_low_next;
  logic                      full_now;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [WORD_W-1:0]         mem_wdata;
  logic                      mem_re;
  logic [ADDR_W-1:0]         mem_raddr;
  logic [WORD_W-1:0]         mem_rdata;

  dssm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Full when the two stacks meet; sum one bit wider to avoid wrap.
  assign full_now = ({1'b0, low_level} + {1'b0, high_level}) >= (LEVEL_W + 1)'(DEPTH);

  assign busy = (state == SEQ_POP_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      low_level  <= '0;
      high_level <= '0;
      low_word   <= EMPTY_TOP;
      high_word  <= EMPTY_TOP;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      low_level  <= low_level_next;
      high_level <= high_level_next;
      low_word   <= low_word_next;
      high_word  <= high_word_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    stat     <= stat_next;
    wait_low <= wait_low_next;
  end

  always_comb begin
    state_next      = state;
    low_level_next  = low_level;
    high_level_next = high_level;
    low_word_next   = low_word;
    high_word_next  = high_word;
    stat_next       = stat;
    wait_low_next   = wait_low;
    done_next       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = push_value;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          stat_next = ST_DONE;
          case (action)
            ACT_PUSH_LOW: begin
              if (full_now) begin
                stat_next = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = low_level[ADDR_W-1:0];
                low_level_next = low_level + LEVEL_W'(1);
                low_word_next  = push_value;
              end
            end
            ACT_PUSH_HIGH: begin
              if (full_now) begin
                stat_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = ADDR_W'(DEPTH - 1) - high_level[ADDR_W-1:0];
                high_level_next = high_level + LEVEL_W'(1);
                high_word_next  = push_value;
              end
            end
            ACT_POP_LOW: begin
              if (low_level == '0) begin
                stat_next = ST_EMPTY;
              end else begin
                low_level_next = low_level - LEVEL_W'(1);
                if (low_level == LEVEL_W'(1)) begin
                  low_word_next = EMPTY_TOP;
                end else begin
                  // Fetch the uncovered top; hold the result back until the read data arrives.
                  mem_re        = 1'b1;
                  mem_raddr     = ADDR_W'(low_level - LEVEL_W'(2));
                  wait_low_next = 1'b1;
                  done_next     = 1'b0;
                  state_next    = SEQ_POP_WAIT;
                end
              end
            end
            ACT_POP_HIGH: begin
              if (high_level == '0) begin
                stat_next = ST_EMPTY;
              end else begin
                high_level_next = high_level - LEVEL_W'(1);
                if (high_level == LEVEL_W'(1)) begin
                  high_word_next = EMPTY_TOP;
                end else begin
                  mem_re        = 1'b1;
                  mem_raddr     = ADDR_W'(DEPTH - 1)
                                  - ADDR_W'(high_level - LEVEL_W'(2));
                  wait_low_next = 1'b0;
                  done_next     = 1'b0;
                  state_next    = SEQ_POP_WAIT;
                end
              end
            end
            default: begin
              // Query and unused codes: report only.
            end
          endcase
        end
      end
      SEQ_POP_WAIT: begin
        // Read data is valid now; refresh the cached top and report.
        if (wait_low) begin
          low_word_next = mem_rdata;
        end else begin
          high_word_next = mem_rdata;
        end
        done_next  = 1'b1;
        state_next = SEQ_IDLE;
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  // Result fields come straight from the state registers, which hold the
  // post-command values during the strobe cycle.
  assign status     = stat;
  assign low_top    = low_word;
  assign high_top   = high_word;
  assign low_count  = low_level;
  assign high_count = high_level;
  assign low_empty  = (low_level == '0);
  assign high_empty = (high_level == '0);
  assign full_res   = full_now;

endmodule

### bench/tb_dual_stack_shared_memory.sv
// Self-checking testbench for the dual stack shared memory block.
`timescale 1ns / 1ps

module tb_dual_stack_shared_memory;
  import dssm_pkg::*;

  // Action codes 5 to 7 have no meaning of their own; the block treats them as a query.
  localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_C = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  localparam int RANDOM_PER_PHASE = 300;
  localparam int DRAIN_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 200000;

  typedef struct {
    logic [ACTION_W-1:0]      act;
    logic signed [WORD_W-1:0] value;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] low_top;
    logic signed [WORD_W-1:0] high_top;
    logic [LEVEL_W-1:0]       low_count;
    logic [LEVEL_W-1:0]       high_count;
    logic                     low_empty;
    logic                     high_empty;
    logic                     full_res;
  } stack_view_t;

  // Random bursts: grow the stacks, drain them, or mix freely.
  typedef enum {BURST_GROW, BURST_DRAIN, BURST_CHURN} burst_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ACTION_W-1:0] action = ACT_QUERY;
  logic signed [WORD_W-1:0] push_value = '0;

  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic signed [WORD_W-1:0] low_top;
  logic signed [WORD_W-1:0] high_top;
  logic [LEVEL_W-1:0] low_count;
  logic [LEVEL_W-1:0] high_count;
  logic low_empty;
  logic high_empty;
  logic full_res;

  // Commands waiting for the driver, and stack views waiting for the block.
  command_t    pending_cmds[$];
  stack_view_t expected_views[$];

  // Private copy of the stacks: shared words plus the two fill levels.
  logic signed [WORD_W-1:0] shadow_mem[DEPTH];
  int unsigned low_level_q  = 0;
  int unsigned high_level_q = 0;

  int idle_pct     = 11;
  int error_count  = 0;
  int views_seen   = 0;
  int push_refused = 0;
  int pop_refused  = 0;
  int full_hits    = 0;
  int cycle_count  = 0;

  dual_stack_shared_memory u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .push_value (push_value),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .low_top    (low_top),
    .high_top   (high_top),
    .low_count  (low_count),
    .high_count (high_count),
    .low_empty  (low_empty),
    .high_empty (high_empty),
    .full_res   (full_res)
  );

  always #1 clk = ~clk;

  // Apply one command to the shadow stacks and return the view the block must report.
  function automatic stack_view_t step_stacks(logic [ACTION_W-1:0] act,
                                              logic signed [WORD_W-1:0] value);
    stack_view_t v;
    logic        full_now;
    full_now = (low_level_q + high_level_q) >= DEPTH;
    v.status = ST_DONE;
    case (act)
      ACT_PUSH_LOW: begin
        if (full_now) begin
          v.status = ST_FULL;
        end else begin
          shadow_mem[ADDR_W'(low_level_q)] = value;
          low_level_q++;
        end
      end
      ACT_PUSH_HIGH: begin
        if (full_now) begin
          v.status = ST_FULL;
        end else begin
          high_level_q++;
          shadow_mem[ADDR_W'(DEPTH - high_level_q)] = value;
        end
      end
      ACT_POP_LOW: begin
        if (low_level_q == 0) v.status = ST_EMPTY;
        else low_level_q--;
      end
      ACT_POP_HIGH: begin
        if (high_level_q == 0) v.status = ST_EMPTY;
        else high_level_q--;
      end
      default: ;
    endcase
    v.low_top    = (low_level_q == 0) ? EMPTY_TOP : shadow_mem[ADDR_W'(low_level_q - 1)];
    v.high_top   = (high_level_q == 0) ? EMPTY_TOP
                                       : shadow_mem[ADDR_W'(DEPTH - high_level_q)];
    v.low_count  = LEVEL_W'(low_level_q);
    v.high_count = LEVEL_W'(high_level_q);
    v.low_empty  = (low_level_q == 0);
    v.high_empty = (high_level_q == 0);
    v.full_res   = (low_level_q + high_level_q) >= DEPTH;
    return v;
  endfunction

  // Driver: record the item taken at this edge, then hold, present the next one, or idle.
  always @(posedge clk) begin
    command_t    nxt;
    stack_view_t v;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        v = step_stacks(action, push_value);
        expected_views.push_back(v);
        if (v.status == ST_FULL) push_refused++;
        if (v.status == ST_EMPTY) pop_refused++;
        if (v.full_res) full_hits++;
      end
      if (start && busy) begin
        // Hold the item on the ports until the block takes it.
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_cmds.pop_front();
        start      <= 1'b1;
        action     <= nxt.act;
        push_value <= nxt.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_field(string field, logic [WORD_W-1:0] exp_val,
                              logic [WORD_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
      error_count++;
    end
  endtask

  // Monitor: each strobed view is checked against the oldest expectation.
  always @(posedge clk) begin
    stack_view_t v;
    if (!rst && done) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time, status);
        error_count++;
      end else begin
        v = expected_views.pop_front();
        views_seen++;
        report_field("status", WORD_W'(v.status), WORD_W'(status));
        report_field("low_top", v.low_top, low_top);
        report_field("high_top", v.high_top, high_top);
        report_field("low_count", WORD_W'(v.low_count), WORD_W'(low_count));
        report_field("high_count", WORD_W'(v.high_count), WORD_W'(high_count));
        report_field("low_empty", WORD_W'(v.low_empty), WORD_W'(low_empty));
        report_field("high_empty", WORD_W'(v.high_empty), WORD_W'(high_empty));
        report_field("full_res", WORD_W'(v.full_res), WORD_W'(full_res));
      end
    end
  end

  // Watchdog: drop the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_item(logic [ACTION_W-1:0] act, logic signed [WORD_W-1:0] value);
    command_t c;
    c.act   = act;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  // Random bursts that push the stacks toward full or empty, with queries and
  // unused codes mixed in as noise.
  task automatic queue_random(int total);
    burst_kind_t kind;
    int          made;
    int          burst_len;
    int          roll;
    int          push_pct;
    int          pop_pct;
    bit          favor_low;
    bit          go_low;
    logic [ACTION_W-1:0]      act;
    logic signed [WORD_W-1:0] value;
    made = 0;
    while (made < total) begin
      kind      = burst_kind_t'($urandom_range(2));
      burst_len = $urandom_range(40, 6);
      favor_low = 1'($urandom_range(1));
      case (kind)
        BURST_GROW:  begin push_pct = 70; pop_pct = 15; end
        BURST_DRAIN: begin push_pct = 20; pop_pct = 70; end
        default:     begin push_pct = 42; pop_pct = 42; end
      endcase
      for (int k = 0; k < burst_len && made < total; k++) begin
        roll   = $urandom_range(99);
        go_low = ($urandom_range(3) != 0) ? favor_low : !favor_low;
        if (roll < push_pct) act = go_low ? ACT_PUSH_LOW : ACT_PUSH_HIGH;
        else if (roll < push_pct + pop_pct) act = go_low ? ACT_POP_LOW : ACT_POP_HIGH;
        else if ($urandom_range(1)) act = ACT_QUERY;
        else act = ACT_UNUSED_A + ACTION_W'($urandom_range(2));
        case ($urandom_range(15))
          0:       value = EMPTY_TOP;
          1:       value = WORD_MAX;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom;
        endcase
        add_item(act, value);
        made++;
      end
    end
  endtask

  // Pause the sender until every queued item is taken and every view has come back.
  task automatic wait_quiet();
    while (pending_cmds.size() > 0 || start || expected_views.size() > 0) @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_mem[ADDR_W'(i)] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stacks, unused codes, extreme words, fill to full, refusals.
    add_item(ACT_QUERY, '0);
    add_item(ACT_POP_LOW, '0);
    add_item(ACT_POP_HIGH, '1);
    add_item(ACT_UNUSED_A, WORD_MAX);
    add_item(ACT_UNUSED_B, EMPTY_TOP);
    add_item(ACT_UNUSED_C, '1);
    add_item(ACT_PUSH_LOW, EMPTY_TOP);
    add_item(ACT_PUSH_HIGH, WORD_MAX);
    add_item(ACT_PUSH_LOW, '0);
    add_item(ACT_PUSH_HIGH, '1);
    for (int k = 0; k < DEPTH - 4; k++) add_item(k[0] ? ACT_PUSH_HIGH : ACT_PUSH_LOW, $urandom);
    add_item(ACT_PUSH_LOW, WORD_MAX);
    add_item(ACT_PUSH_HIGH, EMPTY_TOP);
    add_item(ACT_POP_LOW, '0);
    add_item(ACT_POP_HIGH, '0);

    // Phase one: sender idles now and then.
    idle_pct = 11;
    queue_random(RANDOM_PER_PHASE);
    wait_quiet();

    // Phase two: sender idles most of the time.
    idle_pct = 77;
    queue_random(RANDOM_PER_PHASE);
    wait_quiet();

    // Phase three: back-to-back items.
    idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    wait_quiet();

    // Let a late pop finish, then flag anything left unmatched.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_views.size());
      error_count++;
    end

    $display("Checked %0d stack views over three idle profiles, %0d mismatches.",
             views_seen, error_count);
    $display("Refused pushes %0d, refused pops %0d, views with both stacks full %0d.",
             push_refused, pop_refused, full_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
design/dssm_pkg.sv
design/dssm_ram.sv
design/dual_stack_shared_memory.sv
bench/tb_dual_stack_shared_memory.sv
